// File: design/as_pkg.sv
// Package for the array sorter: word and carry types shared by the cell chain.
// No dependencies.
package as_pkg;

    localparam int unsigned WordWidth = 32;

    typedef logic signed [WordWidth-1:0] t_word;

    // Word moving between neighboring cells, with its valid flag
    typedef struct packed {
        logic  valid;
        t_word value;
    } t_carry;

    // Per-cycle control driven to every cell of the chain
    typedef struct packed {
        logic shift;    // move held words one cell toward the head
    } t_cell_ctrl;

endpackage

// File: design/as_if.sv
// Handshake channels of the array sorter: input item and sorted result item.
// Depends on as_pkg.
interface as_in_if;
    logic                valid;
    logic                ready;
    as_pkg::t_word       value;
    logic                last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface as_out_if;
    logic                valid;
    logic                ready;
    as_pkg::t_word       sorted_value;
    logic                end_of_block;
    logic                dropped;

    modport source (output valid, output sorted_value, output end_of_block,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input end_of_block,
                    input dropped, output ready);
endinterface

// File: design/as_cell.sv
// One cell of the systolic insertion chain: holds one word, keeps the smaller
// of held and arriving words, passes the larger one right. Depends on as_pkg.
module as_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  as_pkg::t_cell_ctrl i_ctrl,
    input  as_pkg::t_carry     i_carry,
    input  as_pkg::t_carry     i_held_in,
    output as_pkg::t_carry     o_carry,
    output as_pkg::t_carry     o_held
);
    import as_pkg::*;

    t_carry r_held;
    t_carry r_carry;
    t_carry n_held;
    t_carry n_carry;

    always_comb begin
        n_held        = r_held;
        n_carry.valid = 1'b0;
        n_carry.value = i_carry.value;
        if (i_ctrl.shift) begin
            n_held = i_held_in;
        end else if (i_carry.valid) begin
            if (!r_held.valid) begin
                n_held = i_carry;
            end else if ($signed(i_carry.value) < $signed(r_held.value)) begin
                // keep the smaller word, push the old one on
                n_held  = i_carry;
                n_carry = r_held;
            end else begin
                n_carry = i_carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held.value  <= n_held.value;
        r_carry.value <= n_carry.value;
        if (!i_rst_n) begin
            r_held.valid  <= 1'b0;
            r_carry.valid <= 1'b0;
        end else begin
            r_held.valid  <= n_held.valid;
            r_carry.valid <= n_carry.valid;
        end
    end

    assign o_carry = r_carry;
    assign o_held  = r_held;

endmodule

// File: design/array_sorter.sv
// Array sorter top level: load a block of signed words, emit them sorted.
// Depends on as_pkg, as_if (as_in_if, as_out_if) and as_cell.
//
// i_in carries one signed 32-bit value per item plus a last flag. Values are
// taken one per cycle while the block loads; each enters the head of a row of
// MAX_ITEMS cells and ripples right one cell per cycle until it finds its place,
// so the row always holds its words in ascending order. Values beyond MAX_ITEMS
// are discarded and every result of that block is flagged dropped.
// After the last item, stop taking input and wait until no word is in flight,
// then drive o_out from the head cell, smallest first; each accepted result
// shifts the row one cell toward the head. end_of_block marks the final result.
// The first result is offered once ST_SETTLE sees no word left rippling down
//   the chain after the last item is taken.
// Throughput: one item per cycle while loading, one result per cycle while
//   draining unless o_out stalls; a new block is taken the cycle after the
//   final result.
// Reset clears every cell's valid flag, the count and the dropped flag.
// A stall on o_out holds the head word and all state until it is taken.
module array_sorter #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    as_in_if.sink          i_in,
    as_out_if.source       o_out
);
    import as_pkg::*;

    localparam int unsigned CountWidth = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_EMIT
    } t_state;

    t_state                r_state;
    logic [CountWidth-1:0] r_count;   // words stored, then words still to emit
    logic                  r_ovf;

    logic       w_in_acc;
    logic       w_store;
    logic       w_out_acc;
    logic       w_busy;
    t_cell_ctrl w_ctrl;

    t_carry w_carry [0:MAX_ITEMS];
    t_carry w_held  [0:MAX_ITEMS];

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_store   = w_in_acc && (r_count < CountWidth'(MAX_ITEMS));
    assign w_out_acc = o_out.valid && o_out.ready;

    assign w_ctrl.shift = w_out_acc;

    // Inject stored values (accepted while the row has room) at the head of the chain
    assign w_carry[0].valid = w_store;
    assign w_carry[0].value = i_in.value;

    // Nothing to pull in behind the tail cell
    assign w_held[MAX_ITEMS].valid = 1'b0;
    assign w_held[MAX_ITEMS].value = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            as_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_carry   (w_carry[g]),
                .i_held_in (w_held[g+1]),
                .o_carry   (w_carry[g+1]),
                .o_held    (w_held[g])
            );
        end
    endgenerate

    // Any word still rippling down the chain blocks emission
    always_comb begin
        w_busy = 1'b0;
        for (int k = 1; k <= MAX_ITEMS; k++) begin
            w_busy = w_busy | w_carry[k].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_store) begin
                        r_count <= r_count + CountWidth'(1);
                    end
                    if (w_in_acc && !w_store) begin
                        r_ovf <= 1'b1;
                    end
                    if (w_in_acc && i_in.last) begin
                        r_state <= ST_SETTLE;
                    end
                end
                ST_SETTLE: begin
                    if (!w_busy) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_acc) begin
                        r_count <= r_count - CountWidth'(1);
                        if (r_count == CountWidth'(1)) begin
                            r_ovf   <= 1'b0;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == ST_LOAD);
    assign o_out.valid        = (r_state == ST_EMIT) && w_held[0].valid;
    assign o_out.sorted_value = w_held[0].value;
    assign o_out.end_of_block = (r_count == CountWidth'(1));
    assign o_out.dropped      = r_ovf;

endmodule

// File: design/as_checker.sv
// Port-level checker for the array sorter, attached to every array_sorter.
// Depends on as_pkg; bound to array_sorter below.
module as_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_in_last,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input as_pkg::t_word i_out_value,
    input logic          i_out_end,
    input logic          i_out_dropped
);
    import as_pkg::*;

    // A stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_value)))
        else $error("stalled result changed");

    // Loading and draining never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while emitting");

    // Closing item drops input ready
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("input taken after last item");

    // Final result ends the block
    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_end) |=> !i_out_valid)
        else $error("result after end of block");

    // Dropped flag is the same across a block, and results follow back to back
    a_drop_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_end) |=>
            (i_out_valid && (i_out_dropped == $past(i_out_dropped))))
        else $error("dropped flag changed within a block");

endmodule

bind array_sorter as_checker u_as_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_last     (i_in.last),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_value   (o_out.sorted_value),
    .i_out_end     (o_out.end_of_block),
    .i_out_dropped (o_out.dropped)
);
